// ===== rtl/core/fdrc_pkg.sv =====
// fdrc_pkg: shared constants and types of the fdr p-value correction block
// no dependencies; imported by every module of the block

package fdrc_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int P_W       = 33;
	localparam int PROD_W    = P_W + IDX_W;
	localparam int DATA_W    = 40;
	localparam int OUT_W     = ((IDX_W + P_W + 7) / 8) * 8;
	localparam logic [P_W-1:0] P_ONE = {1'b1, {(P_W-1){1'b0}}};

	// controller states
	typedef enum logic [13:0] {
		ST_COLLECT   = 14'b00000000000001,
		ST_RANK_LOAD = 14'b00000000000010,
		ST_RANK_HOLD = 14'b00000000000100,
		ST_RANK_SCAN = 14'b00000000001000,
		ST_RANK_WR   = 14'b00000000010000,
		ST_CORR_ORD  = 14'b00000000100000,
		ST_CORR_VAL  = 14'b00000001000000,
		ST_CORR_MUL  = 14'b00000010000000,
		ST_DIV_START = 14'b00000100000000,
		ST_DIV_WAIT  = 14'b00001000000000,
		ST_CORR_WR   = 14'b00010000000000,
		ST_OUT_RD    = 14'b00100000000000,
		ST_OUT_LOAD  = 14'b01000000000000,
		ST_OUT_WAIT  = 14'b10000000000000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic collect;
		logic rank_load;
		logic rank_hold;
		logic rank_scan;
		logic rank_wr;
		logic corr_ord;
		logic corr_val;
		logic corr_mul;
		logic div_start;
		logic corr_wr;
		logic out_rd;
		logic out_load;
		logic out_wait;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic batch_end;
		logic scan_done;
		logic a_last;
		logic i_last;
		logic div_done;
		logic k_last;
		logic out_taken;
	} status_t;

endpackage

// ===== rtl/core/fdr_pvalue_correction.sv =====
// fdr_pvalue_correction: Benjamini-Hochberg correction of one batch of p-values.
// P-values (Q1.32, 1.0 = 2^32) stream in, one item per cycle while the block is
// collecting, with tlast on the last one; up to 64 are kept, later items of the
// batch are dropped. After the last item the block ranks every value against
// all others through the single read port of the value store, then scales each
// by n / rank with a bit-serial divider of 39 steps, keeps a running minimum
// limited to 1.0, and returns one result per original position, in order, each
// held until the receiver takes it. No input is taken until a batch is done.
// depends on fdrc_pkg, fdrc_ctrl, fdrc_dpath

module fdr_pvalue_correction import fdrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // p_value[32:0], zero pad
	input  logic              s_axis_tlast,  // last_item
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,  // item_index[5:0], adjusted_p[38:6], zero pad
	output logic              m_axis_tlast   // last_result
);

	cmd_t    cmd;
	status_t status;

	fdrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	fdrc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/core/fdrc_div.sv =====
// fdrc_div: restoring divider, one quotient bit per cycle
// depends on fdrc_pkg

module fdrc_div import fdrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam logic [5:0] LAST_STEP = 6'(PROD_W - 1);

	logic [PROD_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [5:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: remainder and shifting quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : CNT_W'(trial);
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/fdrc_ctrl.sv =====
// fdrc_ctrl: sequencer for collect, rank, correct and output phases
// depends on fdrc_pkg

module fdrc_ctrl import fdrc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT:   if (status.batch_end) state_d = ST_RANK_LOAD;
			ST_RANK_LOAD: state_d = ST_RANK_HOLD;
			ST_RANK_HOLD: state_d = ST_RANK_SCAN;
			ST_RANK_SCAN: if (status.scan_done) state_d = ST_RANK_WR;
			ST_RANK_WR:   state_d = status.a_last ? ST_CORR_ORD : ST_RANK_LOAD;
			ST_CORR_ORD:  state_d = ST_CORR_VAL;
			ST_CORR_VAL:  state_d = ST_CORR_MUL;
			ST_CORR_MUL:  state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (status.div_done) state_d = ST_CORR_WR;
			ST_CORR_WR:   state_d = status.i_last ? ST_OUT_RD : ST_CORR_ORD;
			ST_OUT_RD:    state_d = ST_OUT_LOAD;
			ST_OUT_LOAD:  state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (status.out_taken) state_d = status.k_last ? ST_COLLECT : ST_OUT_RD;
			end
			default:      state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_COLLECT;
		else state_q <= state_d;
	end

	// commands decoded from state
	always_comb begin
		cmd           = '0;
		cmd.collect   = state_q == ST_COLLECT;
		cmd.rank_load = state_q == ST_RANK_LOAD;
		cmd.rank_hold = state_q == ST_RANK_HOLD;
		cmd.rank_scan = state_q == ST_RANK_SCAN;
		cmd.rank_wr   = state_q == ST_RANK_WR;
		cmd.corr_ord  = state_q == ST_CORR_ORD;
		cmd.corr_val  = state_q == ST_CORR_VAL;
		cmd.corr_mul  = state_q == ST_CORR_MUL;
		cmd.div_start = state_q == ST_DIV_START;
		cmd.corr_wr   = state_q == ST_CORR_WR;
		cmd.out_rd    = state_q == ST_OUT_RD;
		cmd.out_load  = state_q == ST_OUT_LOAD;
		cmd.out_wait  = state_q == ST_OUT_WAIT;
	end

endmodule

// ===== rtl/core/fdrc_dpath.sv =====
// fdrc_dpath: stores, rank counter, scaling, running minimum and output register
// depends on fdrc_pkg and fdrc_div

module fdrc_dpath import fdrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,
	output logic              m_axis_tlast
);

	logic [P_W-1:0]   val_mem [MAX_ITEMS];
	logic [IDX_W-1:0] ord_mem [MAX_ITEMS];
	logic [P_W-1:0]   cor_mem [MAX_ITEMS];

	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  a_q, bd_q, rank_q, pos_q;
	logic [CNT_W-1:0]  b_q, i_q, k_q;
	logic              cmpv_q;
	logic [P_W-1:0]    va_q, val_rd_q, cor_rd_q;
	logic [IDX_W-1:0]  ord_rd_q, val_addr;
	logic [PROD_W-1:0] prod_q, run_q, quot, new_run;
	logic              div_done;
	logic              in_acc, goes_ahead;
	logic              out_valid_q, out_last_q;
	logic [OUT_W-1:0]  out_data_q;

	assign s_axis_tready = cmd.collect;
	assign in_acc        = s_axis_tvalid & cmd.collect;

	// value store: write on input, one read port
	always_comb begin
		val_addr = b_q[IDX_W-1:0];
		if (cmd.rank_load) val_addr = a_q;
		else if (cmd.corr_val) val_addr = ord_rd_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc && cnt_q < CNT_W'(MAX_ITEMS)) val_mem[cnt_q[IDX_W-1:0]] <= s_axis_tdata[P_W-1:0];
		val_rd_q <= val_mem[val_addr];
	end

	// order store
	always_ff @(posedge clk) begin
		if (cmd.rank_wr) ord_mem[rank_q] <= a_q;
		ord_rd_q <= ord_mem[i_q[IDX_W-1:0]];
	end

	// corrected store
	always_ff @(posedge clk) begin
		if (cmd.corr_wr) cor_mem[pos_q] <= (new_run > PROD_W'(P_ONE)) ? P_ONE : new_run[P_W-1:0];
		cor_rd_q <= cor_mem[k_q[IDX_W-1:0]];
	end

	// descending order, ties by ascending position
	assign goes_ahead = (val_rd_q > va_q) || (val_rd_q == va_q && bd_q < a_q);

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			rank_q      <= '0;
			cmpv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && cnt_q < CNT_W'(MAX_ITEMS)) cnt_q <= cnt_q + 1'b1;
			if (in_acc && s_axis_tlast) a_q <= '0;
			if (cmd.rank_load) begin
				b_q    <= '0;
				rank_q <= '0;
				cmpv_q <= 1'b0;
			end
			if (cmd.rank_scan) begin
				if (b_q < cnt_q) begin
					b_q    <= b_q + 1'b1;
					cmpv_q <= 1'b1;
				end else begin
					cmpv_q <= 1'b0;
				end
				if (cmpv_q && goes_ahead) rank_q <= rank_q + 1'b1;
			end
			if (cmd.rank_wr) begin
				a_q <= a_q + 1'b1;
				if (status.a_last) i_q <= '0;
			end
			if (cmd.corr_wr) begin
				i_q <= i_q + 1'b1;
				if (status.i_last) k_q <= '0;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			if (cmd.out_wait && status.out_taken) begin
				out_valid_q <= 1'b0;
				k_q         <= k_q + 1'b1;
				if (status.k_last) cnt_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.rank_scan) bd_q <= b_q[IDX_W-1:0];
		if (cmd.rank_hold) va_q <= val_rd_q;
		if (cmd.corr_val) pos_q <= ord_rd_q;
		if (cmd.corr_mul) prod_q <= PROD_W'(val_rd_q) * cnt_q;
		if (cmd.corr_wr) run_q <= new_run;
		if (cmd.out_load) begin
			out_data_q <= OUT_W'({cor_rd_q, k_q[IDX_W-1:0]});
			out_last_q <= (k_q + 1'b1) == cnt_q;
		end
	end

	// scale by n over ascending rank
	fdrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (cnt_q - i_q),
		.done     (div_done),
		.quotient (quot)
	);

	// running minimum down the sorted list
	assign new_run = (i_q == '0 || quot < run_q) ? quot : run_q;

	assign status.batch_end = in_acc & s_axis_tlast;
	assign status.scan_done = (b_q == cnt_q) & ~cmpv_q;
	assign status.a_last    = ({1'b0, a_q} + 1'b1) == cnt_q;
	assign status.i_last    = (i_q + 1'b1) == cnt_q;
	assign status.div_done  = div_done;
	assign status.k_last    = (k_q + 1'b1) == cnt_q;
	assign status.out_taken = out_valid_q & m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// input and output never open together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while a result is pending");

	// item count bounded by the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("item count beyond store depth");

	// a rank always lands inside the batch
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rank_wr |-> ({1'b0, rank_q} < cnt_q))
		else $error("rank outside batch");

	// divisor never zero
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (i_q < cnt_q))
		else $error("zero divisor");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the fdr p-value correction block
// streams batches of p-values, predicts corrected values, checks each result
// depends on fdrc_pkg and fdr_pvalue_correction
`timescale 1ns / 100ps

module tb_top;
	import fdrc_pkg::*;

	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic [P_W-1:0] pval;
		logic           last;
	} stim_row_t;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [P_W-1:0]   adj;
		logic             last;
	} corr_res_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tlast;

	// predictor state
	logic [P_W-1:0] batch_vals[MAX_ITEMS];
	int             batch_cnt;
	corr_res_t      corr_queue[$];
	int             fail_cnt;
	int             idle_cycles;
	int             pending_known;
	logic [P_W-1:0] known_adj[$];

	fdr_pvalue_correction DUT (.*);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predict one batch of corrected values
	task automatic predict_batch();
		int             ord[MAX_ITEMS];
		logic [P_W-1:0] corr[MAX_ITEMS];
		logic [63:0]    scaled;
		logic [63:0]    run_min;
		int             cur, j, n;
		corr_res_t      r;
		n = batch_cnt;
		for (int i = 0; i < n; i++) ord[i] = i;
		for (int i = 1; i < n; i++) begin
			cur = ord[i];
			j = i;
			while (j > 0 && (batch_vals[cur] > batch_vals[ord[j-1]] ||
					(batch_vals[cur] == batch_vals[ord[j-1]] && cur < ord[j-1]))) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = cur;
		end
		run_min = 0;
		for (int i = 0; i < n; i++) begin
			scaled = (64'(batch_vals[ord[i]]) * 64'(n)) / 64'(n - i);
			if (i == 0 || scaled < run_min) run_min = scaled;
			corr[ord[i]] = (run_min > 64'(P_ONE)) ? P_ONE : run_min[P_W-1:0];
		end
		for (int k = 0; k < n; k++) begin
			r.idx  = k[IDX_W-1:0];
			r.adj  = corr[k];
			r.last = (k == n - 1);
			corr_queue.insert(corr_queue.size(), r);
		end
		batch_cnt = 0;
	endtask

	// send one item, predicting on acceptance
	task automatic send_item(input logic [P_W-1:0] pv, input logic lst);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'(pv);
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		if (batch_cnt < MAX_ITEMS) begin
			batch_vals[batch_cnt] = pv;
			batch_cnt++;
		end
		if (lst) predict_batch();
	endtask

	// random gap between bursts
	task automatic maybe_gap(inout int burst);
		int gap;
		if (burst > 0) begin
			burst--;
			return;
		end
		burst = $urandom_range(0, 12);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [P_W-1:0] rand_pval();
		case ($urandom_range(0, 7))
			0: rand_pval = P_ONE;
			1: rand_pval = 0;
			2: rand_pval = {1'b1, 32'($urandom)};
			3: rand_pval = P_W'($urandom_range(0, 15)) << 28;
			default: rand_pval = {1'b0, 32'($urandom)};
		endcase
	endfunction

	// receiver stall pattern
	initial m_axis_tready = 1'b0;
	always @(posedge clk) begin
		int phase;
		phase = int'(($time / 20) % 97);
		if (phase < 30) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 2) != 0);
	end

	// result checking
	always @(posedge clk) begin
		corr_res_t exp_r;
		logic [P_W-1:0] adj;
		logic [IDX_W-1:0] idx;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			idx = m_axis_tdata[IDX_W-1:0];
			adj = m_axis_tdata[IDX_W +: P_W];
			if (corr_queue.size() == 0) begin
				$display("%0t unexpected result idx=%0d adj=%h", $time, idx, adj);
				fail_cnt++;
			end else begin
				exp_r = corr_queue.pop_front();
				if (known_adj.size() > 0 && pending_known > 0) begin
					if (known_adj[0] !== adj) begin
						$display("%0t table mismatch expected %h actual %h",
							$time, known_adj[0], adj);
						fail_cnt++;
					end
					void'(known_adj.pop_front());
					pending_known--;
				end
				if (idx !== exp_r.idx) begin
					$display("%0t index mismatch expected %0d actual %0d",
						$time, exp_r.idx, idx);
					fail_cnt++;
				end
				if (adj !== exp_r.adj) begin
					$display("%0t adjusted_p mismatch idx %0d expected %h actual %h",
						$time, exp_r.idx, exp_r.adj, adj);
					fail_cnt++;
				end
				if (m_axis_tlast !== exp_r.last) begin
					$display("%0t last mismatch idx %0d expected %b actual %b",
						$time, exp_r.idx, exp_r.last, m_axis_tlast);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin
		stim_row_t dir_rows[$];
		int        burst, n_items, blen;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		batch_cnt = 0;
		fail_cnt = 0;
		idle_cycles = 0;
		pending_known = 0;
		burst = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-item batches with obvious answers: value itself, clamped at 1.0
		dir_rows.insert(dir_rows.size(), '{0, 1'b1});
		dir_rows.insert(dir_rows.size(), '{P_ONE, 1'b1});
		dir_rows.insert(dir_rows.size(), '{{P_W{1'b1}}, 1'b1});
		foreach (dir_rows[i]) begin
			known_adj.insert(known_adj.size(),
				(dir_rows[i].pval > P_ONE) ? P_ONE : dir_rows[i].pval);
			pending_known++;
		end
		// ties, descending, ascending, above one
		dir_rows.insert(dir_rows.size(), '{33'h0_4000_0000, 1'b0});
		dir_rows.insert(dir_rows.size(), '{33'h0_4000_0000, 1'b0});
		dir_rows.insert(dir_rows.size(), '{33'h0_4000_0000, 1'b1});
		dir_rows.insert(dir_rows.size(), '{33'h0_0000_0001, 1'b0});
		dir_rows.insert(dir_rows.size(), '{33'h0_8000_0000, 1'b0});
		dir_rows.insert(dir_rows.size(), '{33'h1_8000_0000, 1'b0});
		dir_rows.insert(dir_rows.size(), '{33'h0_FFFF_FFFF, 1'b1});
		dir_rows.insert(dir_rows.size(), '{33'h0_1000_0000, 1'b0});
		dir_rows.insert(dir_rows.size(), '{33'h0_0000_0000, 1'b1});
		foreach (dir_rows[i]) begin
			maybe_gap(burst);
			send_item(dir_rows[i].pval, dir_rows[i].last);
		end

		// full batch plus overflow items, last mark on a dropped item
		for (int i = 0; i < MAX_ITEMS + 3; i++) begin
			maybe_gap(burst);
			send_item(rand_pval(), i == MAX_ITEMS + 2);
		end

		// random batches, mostly small, bringing the total to about 220 items
		n_items = 0;
		while (n_items < 140) begin
			blen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
				: $urandom_range(1, 8);
			for (int i = 0; i < blen; i++) begin
				maybe_gap(burst);
				send_item(rand_pval(), i == blen - 1);
			end
			n_items += blen;
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		while (corr_queue.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
